FILE: hdl/fcbo_pkg.sv
// ----------------------------------------------------------------------------
// fcbo_pkg
// Shared types and constants of the frame cadence band overlay.
// ----------------------------------------------------------------------------
package fcbo_pkg;

    typedef logic [23:0] t_rgb;
    typedef logic [2:0]  t_cfg_idx;

    localparam t_cfg_idx CFG_MODE    = 3'd0;
    localparam t_cfg_idx CFG_ROWS    = 3'd1;
    localparam t_cfg_idx CFG_SLOTS   = 3'd2;
    localparam t_cfg_idx CFG_OFFSET  = 3'd3;
    localparam t_cfg_idx CFG_SEP     = 3'd4;
    localparam t_cfg_idx CFG_WIDTH   = 3'd5;
    localparam t_cfg_idx CFG_HEIGHT  = 3'd6;
    localparam t_cfg_idx CFG_MARKER  = 3'd7;

    localparam logic [1:0] MODE_TOP    = 2'd1;
    localparam logic [1:0] MODE_BOTTOM = 2'd2;

    localparam int LATENCY = 45;

endpackage

FILE: hdl/fcbo_div.sv
// ----------------------------------------------------------------------------
// fcbo_div
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
module fcbo_div #(
    parameter int NW = 32,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];
    logic [DW-1:0] r_rem [NW];

    genvar s;
    generate
        for (s = 0; s < NW; s++) begin : g_stage
            logic [NW-1:0] p_num;
            logic [NW-1:0] p_quo;
            logic [DW-1:0] p_den;
            logic [DW-1:0] p_rem;
            logic [DW:0]   trial;
            logic [DW-1:0] n_rem;
            logic [NW-1:0] n_quo;

            if (s == 0) begin : g_first
                assign p_num = i_num;
                assign p_den = i_den;
                assign p_rem = '0;
                assign p_quo = '0;
            end else begin : g_next
                assign p_num = r_num[s-1];
                assign p_den = r_den[s-1];
                assign p_rem = r_rem[s-1];
                assign p_quo = r_quo[s-1];
            end

            assign trial = {p_rem, p_num[NW-1-s]};

            always_comb begin
                n_quo = p_quo;
                if (trial >= {1'b0, p_den}) begin
                    n_rem = DW'(trial - {1'b0, p_den});
                    n_quo[NW-1-s] = 1'b1;
                end else begin
                    n_rem = trial[DW-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                r_num[s] <= p_num;
                r_den[s] <= p_den;
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
            end
        end
    endgenerate

    assign o_quo = r_quo[NW-1];
    assign o_rem = r_rem[NW-1];

endmodule

FILE: hdl/fcbo_delay.sv
// ----------------------------------------------------------------------------
// fcbo_delay
// Fixed-length register line that aligns side data with the pipeline.
// ----------------------------------------------------------------------------
module fcbo_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [D];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int k = 1; k < D; k++) begin
            r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[D-1];

endmodule

FILE: hdl/frame_cadence_band_overlay.sv
// ----------------------------------------------------------------------------
// frame_cadence_band_overlay
// Per-pixel overlay of a slotted cadence band on an RGB stream.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock (busy stays low) and its result appears
// on o_valid in the order taken; the result ports cannot be held off.
// The pixel path runs through two chained divider pipelines that locate the
// nearest slot separator (21 stages each) plus the input, clamp and output
// registers. Configuration must only change while no pixel is in flight.
// ----------------------------------------------------------------------------
module frame_cadence_band_overlay #(
    parameter int unsigned ROW_ROUNDING      = 1,
    parameter int unsigned DEFAULT_BAND_ROWS = 16,
    parameter int unsigned BACKGROUND_RGB    = 1710618,
    parameter int unsigned SEPARATOR_RGB     = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [11:0]         i_pixel_x,
    input  logic [11:0]         i_pixel_y,
    input  logic [31:0]         i_frame_number,
    input  fcbo_pkg::t_rgb      i_pixel_in,
    input  logic                i_cfg_we,
    input  fcbo_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [23:0]         i_cfg_data,
    output logic                o_valid,
    output fcbo_pkg::t_rgb      o_pixel_out,
    output logic                o_overlay_applied
);
    import fcbo_pkg::*;

    localparam int unsigned RND_RECIP = ((1 << 14) + ROW_ROUNDING - 1) / ROW_ROUNDING;

    logic [1:0]  r_mode;
    logic [11:0] r_rows;
    logic [7:0]  r_slots;
    logic [15:0] r_off;
    logic [7:0]  r_sep;
    logic [12:0] r_w;
    logic [12:0] r_h;
    t_rgb        r_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd0;
            r_rows   <= 12'd16;
            r_slots  <= 8'd0;
            r_off    <= 16'd0;
            r_sep    <= 8'd1;
            r_w      <= 13'd1920;
            r_h      <= 13'd1080;
            r_marker <= 24'h1AD933;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_ROWS:   r_rows   <= i_cfg_data[11:0];
                CFG_SLOTS:  r_slots  <= i_cfg_data[7:0];
                CFG_OFFSET: r_off    <= i_cfg_data[15:0];
                CFG_SEP:    r_sep    <= i_cfg_data[7:0];
                CFG_WIDTH:  r_w      <= i_cfg_data[12:0];
                CFG_HEIGHT: r_h      <= i_cfg_data[12:0];
                CFG_MARKER: r_marker <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic        accept;
    logic [11:0] req;
    logic [13:0] req_up;
    logic [27:0] rnd_prod;
    logic [13:0] rnd_q;
    logic [12:0] band_h;
    logic [12:0] top;
    logic [13:0] lim;
    logic        in_band;
    logic [7:0]  bw;
    logic [6:0]  half;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign req      = (r_rows != 12'd0) ? r_rows : 12'(DEFAULT_BAND_ROWS);
    // round up by reciprocal multiplication
    assign req_up   = 14'(req) + 14'(ROW_ROUNDING - 1);
    assign rnd_prod = 28'(req_up) * 28'(RND_RECIP);
    assign rnd_q    = rnd_prod[27:14];
    assign band_h   = 13'(rnd_q * 14'(ROW_ROUNDING));
    assign top      = (r_mode == MODE_TOP) ? 13'd0 : r_h - band_h;
    assign lim      = 14'(top) + 14'(band_h);
    assign bw       = (r_sep != 8'd0) ? r_sep : 8'd1;
    assign half     = bw[7:1];

    assign in_band = (r_mode == MODE_TOP || r_mode == MODE_BOTTOM) && (r_slots != 8'd0)
                     && (band_h <= r_h) && (13'(i_pixel_x) < r_w) && (13'(i_pixel_y) < r_h)
                     && (13'(i_pixel_y) >= top) && (14'(i_pixel_y) < lim);

    // active slot
    logic [31:0] frm_quo;
    logic [7:0]  frm_rem;
    logic [15:0] um_quo;
    logic [7:0]  um_rem;
    logic [15:0] c_quo;
    logic [7:0]  c_rem;
    logic [7:0]  um_d;
    logic [7:0]  c_d;
    logic [8:0]  offm;
    logic [8:0]  asum;
    logic [7:0]  n_act;
    logic [7:0]  r_act;
    logic [7:0]  act_d;

    fcbo_div #(.NW(32), .DW(8)) u_div_frm (
        .i_clk(i_clk), .i_num(i_frame_number), .i_den(r_slots),
        .o_quo(frm_quo), .o_rem(frm_rem)
    );
    fcbo_div #(.NW(16), .DW(8)) u_div_off (
        .i_clk(i_clk), .i_num(r_off ^ 16'h8000), .i_den(r_slots),
        .o_quo(um_quo), .o_rem(um_rem)
    );
    fcbo_div #(.NW(16), .DW(8)) u_div_bias (
        .i_clk(i_clk), .i_num(16'h8000), .i_den(r_slots),
        .o_quo(c_quo), .o_rem(c_rem)
    );
    fcbo_delay #(.W(8), .D(16)) u_dly_um (.i_clk(i_clk), .i_d(um_rem), .o_q(um_d));
    fcbo_delay #(.W(8), .D(16)) u_dly_c  (.i_clk(i_clk), .i_d(c_rem),  .o_q(c_d));

    always_comb begin
        offm  = (um_d >= c_d) ? 9'(um_d) - 9'(c_d) : 9'(um_d) + 9'(r_slots) - 9'(c_d);
        asum  = 9'(frm_rem) + offm;
        n_act = (asum >= 9'(r_slots)) ? 8'(asum - 9'(r_slots)) : asum[7:0];
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
    end

    fcbo_delay #(.W(8), .D(11)) u_dly_act (.i_clk(i_clk), .i_d(r_act), .o_q(act_d));

    // slot index and nearest inner separator
    logic [20:0] r_numk;
    logic [20:0] r_numj;
    logic [20:0] k_quo;
    logic [12:0] k_rem;
    logic [20:0] j_quo;
    logic [12:0] j_rem;
    logic [7:0]  k_d;
    logic [7:0]  jc;
    logic [20:0] r_prod;
    logic        r_jv;
    logic        jv_d;
    logic [20:0] s_quo;
    logic [7:0]  s_rem;

    always_ff @(posedge i_clk) begin
        r_numk <= 21'(13'(i_pixel_x) + 13'd1) * 21'(r_slots) - 21'd1;
        r_numj <= 21'(13'(i_pixel_x) + 13'(half) + 13'd1) * 21'(r_slots) - 21'd1;
    end

    fcbo_div #(.NW(21), .DW(13)) u_div_k (
        .i_clk(i_clk), .i_num(r_numk), .i_den(r_w), .o_quo(k_quo), .o_rem(k_rem)
    );
    fcbo_div #(.NW(21), .DW(13)) u_div_j (
        .i_clk(i_clk), .i_num(r_numj), .i_den(r_w), .o_quo(j_quo), .o_rem(j_rem)
    );
    fcbo_delay #(.W(8), .D(22)) u_dly_k (.i_clk(i_clk), .i_d(k_quo[7:0]), .o_q(k_d));

    assign jc = (j_quo >= 21'(r_slots)) ? r_slots - 8'd1 : j_quo[7:0];

    always_ff @(posedge i_clk) begin
        r_prod <= 21'(jc) * 21'(r_w);
        r_jv   <= (jc != 8'd0);
    end

    fcbo_div #(.NW(21), .DW(8)) u_div_s (
        .i_clk(i_clk), .i_num(r_prod), .i_den(r_slots), .o_quo(s_quo), .o_rem(s_rem)
    );
    fcbo_delay #(.W(1), .D(21)) u_dly_jv (.i_clk(i_clk), .i_d(r_jv), .o_q(jv_d));

    // side data
    logic [11:0] x_d;
    t_rgb        pix_d;
    logic        band_d;

    fcbo_delay #(.W(12), .D(44)) u_dly_x    (.i_clk(i_clk), .i_d(i_pixel_x),  .o_q(x_d));
    fcbo_delay #(.W(24), .D(44)) u_dly_pix  (.i_clk(i_clk), .i_d(i_pixel_in), .o_q(pix_d));
    fcbo_delay #(.W(1),  .D(44)) u_dly_band (.i_clk(i_clk), .i_d(in_band),    .o_q(band_d));

    // final select
    logic [12:0] s_j;
    logic [12:0] sep_l;
    logic [12:0] sep_s;
    logic        on_sep;
    t_rgb        n_pix;
    t_rgb        r_pix;
    logic        r_app;

    always_comb begin
        s_j    = s_quo[12:0];
        sep_l  = (r_w > 13'(bw)) ? r_w - 13'(bw) : 13'd0;
        sep_s  = (s_j > 13'(half)) ? s_j - 13'(half) : 13'd0;
        on_sep = (12'(x_d) < 12'(bw)) || (13'(x_d) >= sep_l)
                 || (jv_d && (14'(x_d) < 14'(sep_s) + 14'(bw)));
        if (!band_d) begin
            n_pix = pix_d;
        end else if (on_sep) begin
            n_pix = 24'(SEPARATOR_RGB);
        end else if (k_d == act_d) begin
            n_pix = r_marker;
        end else begin
            n_pix = 24'(BACKGROUND_RGB);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
        r_app <= band_d;
    end

    logic [LATENCY-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    assign o_valid           = r_vld[LATENCY-1];
    assign o_pixel_out       = r_pix;
    assign o_overlay_applied = r_app && r_vld[LATENCY-1];

endmodule

FILE: hdl/fcbo_checker.sv
// ----------------------------------------------------------------------------
// fcbo_checker
// Port-level checks of the overlay: fixed latency, pass-through and flag qualification.
// ----------------------------------------------------------------------------
module fcbo_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input fcbo_pkg::t_rgb i_pixel_in,
    input logic           o_valid,
    input fcbo_pkg::t_rgb o_pixel_out,
    input logic           o_overlay_applied
);
    import fcbo_pkg::*;

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("beat out without matching beat in");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("beat in lost");

    a_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overlay_applied) |-> (o_pixel_out == $past(i_pixel_in, LATENCY)))
        else $error("pass-through pixel altered");

    a_flag_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_overlay_applied |-> o_valid)
        else $error("overlay flag without beat");

endmodule

bind frame_cadence_band_overlay fcbo_checker u_fcbo_checker (.*);
